/* hw/rtl/stable_sorted_priority_queue_macros.svh */
// Assertion macros for the stable sorted priority queue.
// Depends on nothing; included by modules that carry assertions.
`ifndef STABLE_SORTED_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SSPQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SSPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/sspq_pkg.sv */
// Shared types and constants for the stable sorted priority queue.
// No dependencies; used by sspq_cell and stable_sorted_priority_queue.
package sspq_pkg;

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_PEEK    = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Command broadcast to every cell of the row.
    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_SHIFT  = 2'd2,
        CMD_FLUSH  = 2'd3
    } t_cmd;

    localparam logic signed [31:0] DATA_EMPTY = -32'sd1;
    localparam logic signed [31:0] DATA_NONE  = 32'sd0;

    typedef struct packed {
        t_op                kind;
        logic signed [31:0] value;
        logic [7:0]         priority_req;
    } t_req;

    typedef struct packed {
        logic signed [31:0] data;
        logic [1:0]         status;
        logic [4:0]         occupancy;
        logic               is_empty;
    } t_rsp;

    // Contents of one cell as seen by its neighbors.
    typedef struct packed {
        logic signed [31:0] value;
        logic [7:0]         prio;
        logic               used;
    } t_slot;

endpackage

/* hw/rtl/sspq_cell.sv */
// One compare-and-shift cell of the sorted row: holds one entry.
// Depends on sspq_pkg.
module sspq_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sspq_pkg::t_cmd       i_cmd,
    input  logic signed [31:0]   i_new_value,
    input  logic [7:0]           i_new_prio,
    input  sspq_pkg::t_slot      i_left,
    input  logic                 i_left_keep,
    input  sspq_pkg::t_slot      i_right,
    output sspq_pkg::t_slot      o_slot,
    output logic                 o_keep
);

    logic signed [31:0] r_value, n_value;
    logic [7:0]         r_prio,  n_prio;
    logic               r_used,  n_used;

    // Entry stays ahead of a new request of this priority.
    assign o_keep = r_used && (r_prio <= i_new_prio);

    always_comb begin
        n_value = r_value;
        n_prio  = r_prio;
        n_used  = r_used;
        unique case (i_cmd)
            sspq_pkg::CMD_HOLD: begin
            end
            sspq_pkg::CMD_INSERT: begin
                if (o_keep) begin
                end else if (i_left_keep) begin
                    n_value = i_new_value;
                    n_prio  = i_new_prio;
                    n_used  = 1'b1;
                end else begin
                    n_value = i_left.value;
                    n_prio  = i_left.prio;
                    n_used  = i_left.used;
                end
            end
            sspq_pkg::CMD_SHIFT: begin
                n_value = i_right.value;
                n_prio  = i_right.prio;
                n_used  = i_right.used;
            end
            sspq_pkg::CMD_FLUSH: begin
                n_used = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else begin
            r_used <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_prio  <= n_prio;
    end

    assign o_slot.value = r_value;
    assign o_slot.prio  = r_prio;
    assign o_slot.used  = r_used;

endmodule

/* hw/rtl/stable_sorted_priority_queue.sv */
// Stable sorted priority queue: one request per clock, response in the next
// cycle from an output register. Entries live in a row of DEPTH compare-and-
// shift cells, front at cell 0; every cell compares its priority with the
// incoming one in parallel, so an enqueue, dequeue, peek or clear updates the
// row at once regardless of fill. A lower number is more urgent, and equal
// priorities leave in arrival order. Request stall rises only while a response
// waits and the response side stalls. No clearing pass after reset.
// Depends on sspq_pkg, sspq_cell and stable_sorted_priority_queue_macros.svh.
module stable_sorted_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_stall,
    input  sspq_pkg::t_req  i_req,
    output logic            o_rsp_valid,
    input  logic            i_rsp_stall,
    output sspq_pkg::t_rsp  o_rsp
);

    `include "stable_sorted_priority_queue_macros.svh"

    localparam int CNT_W = $clog2(DEPTH + 1);

    sspq_pkg::t_slot slot [DEPTH];
    logic [DEPTH-1:0] keep;
    logic [DEPTH-1:0] used_vec;
    sspq_pkg::t_cmd   cmd;

    logic req_fire;
    logic full, empty;

    logic [CNT_W-1:0] r_count, n_count;
    logic             r_rsp_valid, n_rsp_valid;
    sspq_pkg::t_rsp   r_rsp, n_rsp;

    // Accept while no response waits, or while the waiting one leaves now.
    assign o_req_stall = r_rsp_valid && i_rsp_stall;
    assign req_fire    = i_req_valid && !o_req_stall;

    assign full  = slot[DEPTH-1].used;
    assign empty = !slot[0].used;

    // Row of cells: left neighbor feeds inserts, right neighbor feeds pops.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        sspq_pkg::t_slot left_slot, right_slot;
        logic            left_keep;

        if (g == 0) begin : g_head
            assign left_slot = '0;
            assign left_keep = 1'b1;
        end else begin : g_mid
            assign left_slot = slot[g-1];
            assign left_keep = keep[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign right_slot = '0;
        end else begin : g_body
            assign right_slot = slot[g+1];
        end

        sspq_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (cmd),
            .i_new_value (i_req.value),
            .i_new_prio  (i_req.priority_req),
            .i_left      (left_slot),
            .i_left_keep (left_keep),
            .i_right     (right_slot),
            .o_slot      (slot[g]),
            .o_keep      (keep[g])
        );

        assign used_vec[g] = slot[g].used;
    end

    // Decode the request into a row command, the new count and the response.
    always_comb begin
        cmd          = sspq_pkg::CMD_HOLD;
        n_count      = r_count;
        n_rsp        = r_rsp;
        n_rsp_valid  = r_rsp_valid && i_rsp_stall;

        if (req_fire) begin
            n_rsp_valid = 1'b1;
            n_rsp.data   = sspq_pkg::DATA_NONE;
            n_rsp.status = sspq_pkg::ST_OK;
            unique case (i_req.kind)
                sspq_pkg::OP_ENQUEUE: begin
                    if (full) begin
                        n_rsp.status = sspq_pkg::ST_FULL;
                    end else begin
                        cmd     = sspq_pkg::CMD_INSERT;
                        n_count = CNT_W'(r_count + 1'b1);
                    end
                end
                sspq_pkg::OP_DEQUEUE, sspq_pkg::OP_PEEK: begin
                    if (empty) begin
                        n_rsp.data   = sspq_pkg::DATA_EMPTY;
                        n_rsp.status = sspq_pkg::ST_EMPTY;
                    end else begin
                        n_rsp.data = slot[0].value;
                        if (i_req.kind == sspq_pkg::OP_DEQUEUE) begin
                            cmd     = sspq_pkg::CMD_SHIFT;
                            n_count = CNT_W'(r_count - 1'b1);
                        end
                    end
                end
                sspq_pkg::OP_CLEAR: begin
                    cmd     = sspq_pkg::CMD_FLUSH;
                    n_count = '0;
                end
                default: begin
                end
            endcase
            // Occupancy reports the count modulo 32.
            n_rsp.occupancy = 5'(n_count);
            n_rsp.is_empty  = (n_count == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    // Response payload needs no reset.
    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // Occupied cells always form a prefix of the row.
    `SSPQ_ASSERT_NOW(a_used_prefix, i_clk, i_rst_n, 1'b1, ((used_vec + 1'b1) & used_vec) == '0, "occupied cells are not a prefix")
    // Count tracks the number of occupied cells.
    `SSPQ_ASSERT_NOW(a_count_match, i_clk, i_rst_n, 1'b1, $countones(used_vec) == int'(r_count), "entry count disagrees with occupied cells")
    // A refused enqueue leaves the store untouched.
    `SSPQ_ASSERT_NEXT(a_full_hold, i_clk, i_rst_n, req_fire && (i_req.kind == sspq_pkg::OP_ENQUEUE) && full, (r_count == $past(r_count)) && (o_rsp.status == sspq_pkg::ST_FULL), "enqueue on full store changed state")
    // An empty dequeue or peek reports the empty marker.
    `SSPQ_ASSERT_NEXT(a_empty_rsp, i_clk, i_rst_n, req_fire && empty && ((i_req.kind == sspq_pkg::OP_DEQUEUE) || (i_req.kind == sspq_pkg::OP_PEEK)), o_rsp_valid && (o_rsp.data == sspq_pkg::DATA_EMPTY) && (o_rsp.status == sspq_pkg::ST_EMPTY), "empty read did not report empty")

endmodule

/* bench/stable_sorted_priority_queue_tb.sv */
// Self-checking testbench for stable_sorted_priority_queue.
// Needs sspq_pkg and the queue RTL; scores every response against a built-in
// sorted-list predictor while both handshakes idle and stall at random.
module stable_sorted_priority_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = 16;
    localparam int RANDOM_REQS = 1250;
    localparam int CYCLE_LIMIT = 500000;
    localparam int MAX_SHOWN   = 10;

    // DUT inputs start at known values before the first clock edge.
    logic           i_clk;
    logic           i_rst_n     = 1'b0;
    logic           i_req_valid = 1'b0;
    sspq_pkg::t_req i_req       = '0;
    logic           i_rsp_stall = 1'b0;
    logic           o_req_stall;
    logic           o_rsp_valid;
    sspq_pkg::t_rsp o_rsp;

    // Predictor state: a sorted row of entries, front at index 0.
    logic signed [31:0] row_value [SLOTS];
    logic [7:0]         row_prio  [SLOTS];
    int                 row_fill = 0;

    // Traffic between generator, driver and scoreboard.
    sspq_pkg::t_req req_backlog [$];
    sspq_pkg::t_rsp rsp_expected [$];
    int   req_total    = 0;
    int   req_accepted = 0;
    int   rsp_checked  = 0;
    int   fail_count   = 0;
    int   cycle_count  = 0;

    // Coverage tallies for the closing summary.
    int n_refused   = 0;
    int n_empty_hit = 0;
    int n_clears    = 0;
    int n_full_seen = 0;

    // Occupancy as the generator expects it, used to steer toward full/empty.
    int plan_count = 0;

    stable_sorted_priority_queue #(
        .DEPTH(SLOTS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Apply one request to the predictor row and return the response it owes.
    // Insert behind every entry of equal or smaller priority number so that
    // equal priorities drain in arrival order.
    function automatic sspq_pkg::t_rsp apply_queue_op(sspq_pkg::t_req r);
        sspq_pkg::t_rsp rsp;
        int   pos;
        int   i;
        rsp      = '0;
        rsp.data = sspq_pkg::DATA_NONE;
        case (r.kind)
            sspq_pkg::OP_ENQUEUE: begin
                if (row_fill == SLOTS) begin
                    rsp.status = sspq_pkg::ST_FULL;
                    n_refused++;
                end else begin
                    pos = 0;
                    while (pos < row_fill && row_prio[pos] <= r.priority_req)
                        pos++;
                    for (i = row_fill; i > pos; i--) begin
                        row_value[i] = row_value[i-1];
                        row_prio[i]  = row_prio[i-1];
                    end
                    row_value[pos] = r.value;
                    row_prio[pos]  = r.priority_req;
                    row_fill++;
                    if (row_fill == SLOTS)
                        n_full_seen++;
                end
            end
            sspq_pkg::OP_DEQUEUE, sspq_pkg::OP_PEEK: begin
                if (row_fill == 0) begin
                    rsp.data   = sspq_pkg::DATA_EMPTY;
                    rsp.status = sspq_pkg::ST_EMPTY;
                    n_empty_hit++;
                end else begin
                    rsp.data = row_value[0];
                    if (r.kind == sspq_pkg::OP_DEQUEUE) begin
                        for (i = 0; i + 1 < row_fill; i++) begin
                            row_value[i] = row_value[i+1];
                            row_prio[i]  = row_prio[i+1];
                        end
                        row_fill--;
                    end
                end
            end
            default: begin
                row_fill = 0;
                n_clears++;
            end
        endcase
        rsp.occupancy = row_fill[4:0];
        rsp.is_empty  = (row_fill == 0);
        return rsp;
    endfunction

    // Idle run length: mostly none, some short, a few long.
    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Append one request to the backlog and track the planned occupancy.
    task automatic add_req(sspq_pkg::t_op op, logic signed [31:0] val, logic [7:0] prio);
        sspq_pkg::t_req r;
        r.kind         = op;
        r.value        = val;
        r.priority_req = prio;
        req_backlog.push_back(r);
        req_total++;
        case (op)
            sspq_pkg::OP_ENQUEUE: if (plan_count < SLOTS) plan_count++;
            sspq_pkg::OP_DEQUEUE: if (plan_count > 0) plan_count--;
            sspq_pkg::OP_CLEAR:   plan_count = 0;
            default:    ;
        endcase
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return -32'sd1;
            3:       return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    // Narrow priorities half the time so ties, and hence ordering among
    // equal priorities, get exercised heavily.
    function automatic logic [7:0] pick_prio();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return 8'($urandom_range(0, 3));
        else if (r < 8)
            return 8'($urandom_range(0, 255));
        else
            return (r == 8) ? 8'd0 : 8'd255;
    endfunction

    // Request driver: hold the payload while stalled, advance on acceptance.
    int   req_gap  = 0;
    logic req_calm = 1'b0;

    always @(posedge i_clk) begin
        logic take;
        logic nxt_valid;
        take      = i_req_valid && !o_req_stall;
        nxt_valid = i_req_valid;
        if ($urandom_range(0, 99) == 0)
            req_calm = !req_calm;
        if (take) begin
            rsp_expected.push_back(apply_queue_op(i_req));
            req_accepted++;
        end
        if (i_rst_n && (!i_req_valid || take)) begin
            if (req_gap > 0) begin
                req_gap--;
                nxt_valid = 1'b0;
            end else if (req_backlog.size() > 0) begin
                nxt_valid = 1'b1;
                i_req   <= req_backlog.pop_front();
                req_gap  = req_calm ? 0 : pick_idle_len();
            end else begin
                nxt_valid = 1'b0;
            end
            i_req_valid <= nxt_valid;
        end
    end

    // Response stall pattern, with calm stretches of no stall at all.
    int   stall_left = 0;
    logic rsp_calm   = 1'b0;

    always @(posedge i_clk) begin
        if ($urandom_range(0, 99) == 0)
            rsp_calm = !rsp_calm;
        if (stall_left == 0 && !rsp_calm)
            stall_left = pick_idle_len();
        if (stall_left > 0) begin
            stall_left--;
            i_rsp_stall <= 1'b1;
        end else begin
            i_rsp_stall <= 1'b0;
        end
    end

    // Response monitor: compare every accepted response with the oldest
    // expectation, field by field.
    always @(posedge i_clk) begin
        sspq_pkg::t_rsp want;
        if (i_rst_n && o_rsp_valid && !i_rsp_stall) begin
            if (rsp_expected.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_SHOWN)
                    $display("unexpected response: data=%0d status=%0d occ=%0d empty=%0b",
                             o_rsp.data, o_rsp.status, o_rsp.occupancy, o_rsp.is_empty);
            end else begin
                want = rsp_expected.pop_front();
                if (o_rsp.data !== want.data || o_rsp.status !== want.status ||
                    o_rsp.occupancy !== want.occupancy ||
                    o_rsp.is_empty !== want.is_empty) begin
                    fail_count++;
                    if (fail_count <= MAX_SHOWN) begin
                        $display("response %0d mismatch: expected data=%0d status=%0d occ=%0d empty=%0b",
                                 rsp_checked, want.data, want.status, want.occupancy,
                                 want.is_empty);
                        $display("    got data=%0d status=%0d occ=%0d empty=%0b",
                                 o_rsp.data, o_rsp.status, o_rsp.occupancy,
                                 o_rsp.is_empty);
                    end
                end
            end
            rsp_checked++;
        end
    end

    // Watchdog: end the run once the cycle limit is reached.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d of %0d requests accepted",
                 cycle_count, req_accepted, req_total);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int  i;
        int  r;
        logic draining;

        // Directed: empty-queue reads and clear, fill with ties and extreme
        // values, refused enqueue on full, then peek, dequeue, enqueue, clear and a final peek.
        add_req(sspq_pkg::OP_PEEK, 32'sd11, 8'd0);
        add_req(sspq_pkg::OP_DEQUEUE, 32'sd12, 8'd255);
        add_req(sspq_pkg::OP_CLEAR, 32'sd13, 8'd7);
        add_req(sspq_pkg::OP_ENQUEUE, 32'sh7FFF_FFFF, 8'd255);
        add_req(sspq_pkg::OP_ENQUEUE, 32'sh8000_0000, 8'd0);
        add_req(sspq_pkg::OP_ENQUEUE, -32'sd1, 8'd128);
        add_req(sspq_pkg::OP_ENQUEUE, 32'sd0, 8'd0);
        for (i = 4; i < SLOTS; i++) begin
            case (i % 4)
                0:       add_req(sspq_pkg::OP_ENQUEUE, 32'sd100 + i, 8'd0);
                1:       add_req(sspq_pkg::OP_ENQUEUE, -32'sd100 - i, 8'd128);
                2:       add_req(sspq_pkg::OP_ENQUEUE, 32'sd1000 * i, 8'd255);
                default: add_req(sspq_pkg::OP_ENQUEUE, 32'sd7 + i, 8'd7);
            endcase
        end
        add_req(sspq_pkg::OP_ENQUEUE, 32'sd555, 8'd0);
        add_req(sspq_pkg::OP_PEEK, 32'sd0, 8'd0);
        add_req(sspq_pkg::OP_DEQUEUE, 32'sd0, 8'd0);
        add_req(sspq_pkg::OP_ENQUEUE, 32'sd777, 8'd255);
        add_req(sspq_pkg::OP_CLEAR, 32'sd0, 8'd0);
        add_req(sspq_pkg::OP_PEEK, 32'sd0, 8'd0);

        // Random: alternate fill and drain phases so the queue keeps
        // swinging between empty and full, with peeks and rare clears mixed in.
        draining = 1'b0;
        for (i = 0; i < RANDOM_REQS; i++) begin
            if (plan_count == 0)
                draining = 1'b0;
            else if (plan_count == SLOTS && $urandom_range(0, 4) == 0)
                draining = 1'b1;
            else if ($urandom_range(0, 99) < 3)
                draining = !draining;
            r = $urandom_range(0, 99);
            if (r < 2)
                add_req(sspq_pkg::OP_CLEAR, pick_value(), pick_prio());
            else if (r < 12)
                add_req(sspq_pkg::OP_PEEK, pick_value(), pick_prio());
            else if ((r < 77) != draining)
                add_req(sspq_pkg::OP_ENQUEUE, pick_value(), pick_prio());
            else
                add_req(sspq_pkg::OP_DEQUEUE, pick_value(), pick_prio());
        end

        // Hold reset, then release it once.
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: every request accepted, every response back, then keep clocking
        // to catch stray responses.
        while (req_accepted < req_total || rsp_expected.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("%0d requests run, %0d responses checked, queue filled %0d times",
                 req_accepted, rsp_checked, n_full_seen);
        $display("%0d enqueues turned away when full, %0d empty reads, %0d clears",
                 n_refused, n_empty_hit, n_clears);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
